[src/wsjs_pkg.sv]
// Shared constants and types for the work-stealing job scheduler.
`default_nettype none
package wsjs_pkg;
  localparam int WORKERS_DEF      = 4;
  localparam int LOCAL_DEPTH_DEF  = 64;
  localparam int GLOBAL_DEPTH_DEF = 256;
  localparam int JOB_W            = 16;
  localparam int LIMIT_W          = 7;
  localparam int PEND_W           = 10;
  localparam logic [PEND_W-1:0] PENDING_MAX = 10'd1023;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [2:0] {
    ACT_EXT_SUBMIT = 3'd0,
    ACT_WRK_SUBMIT = 3'd1,
    ACT_FETCH      = 3'd2,
    ACT_STOP       = 3'd3,
    ACT_DONE       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_STOPPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_OWN    = 2'd1,
    SRC_GLOBAL = 2'd2,
    SRC_STOLEN = 2'd3
  } source_t;
endpackage
`default_nettype wire

[src/work_stealing_job_scheduler.sv]
// Top level of the work-stealing job scheduler.
// Usage:
//   Input words (in_action, in_worker, in_job_id) enter on in_valid when
//   in_stall is low. Each word yields exactly one result word
//   (out_status, out_job_id_res, out_source, out_pending) on out_valid,
//   taken when out_stall is low.
//   One word is processed at a time: accept (the synchronous read of the
//   local or global store is registered at the accepting edge), a read
//   state, then the result is registered and out_valid rises. The next
//   word is accepted at the edge after the result register is loaded.
//   A steal picks the first non-empty victim from per-worker counters
//   kept in flip-flops, so no extra probe state is needed.
//   cfg_data sets the local deque limit; write it only while idle.
//   A stalled result holds in the output register; one more word may be
//   processed and wait until the register frees.
//   Reset (synchronous, rst_n low) empties all deques and the global FIFO,
//   clears the pending count and the stop flag, and sets the limit to 64.
//   The stores need no clearing pass: only occupied entries are read.
`default_nettype none
module work_stealing_job_scheduler #(
  parameter int WORKERS      = wsjs_pkg::WORKERS_DEF,
  parameter int LOCAL_DEPTH  = wsjs_pkg::LOCAL_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = wsjs_pkg::GLOBAL_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 in_action,
  input  wire logic [1:0]                 in_worker,
  input  wire logic [wsjs_pkg::JOB_W-1:0] in_job_id,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_status,
  output logic [wsjs_pkg::JOB_W-1:0]      out_job_id_res,
  output logic [1:0]                      out_source,
  output logic [wsjs_pkg::PEND_W-1:0]     out_pending,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [wsjs_pkg::LIMIT_W-1:0] cfg_data
);
  localparam int WW  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int LW  = $clog2(LOCAL_DEPTH);
  localparam int LCW = $clog2(LOCAL_DEPTH + 1);
  localparam int LAW = $clog2(WORKERS * LOCAL_DEPTH);
  localparam int GW  = $clog2(GLOBAL_DEPTH);
  localparam int GCW = $clog2(GLOBAL_DEPTH + 1);
  localparam int JW  = wsjs_pkg::JOB_W;
  localparam int PW  = wsjs_pkg::PEND_W;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} state_t;

  logic [JW-1:0] local_mem [WORKERS*LOCAL_DEPTH];
  logic [JW-1:0] global_mem [GLOBAL_DEPTH];

  state_t            state_r;
  logic [LW-1:0]     front_r [WORKERS];
  logic [LCW-1:0]    count_r [WORKERS];
  logic [GW-1:0]     ghead_r;
  logic [GCW-1:0]    gcount_r;
  logic [PW-1:0]     pend_r;
  logic              stop_r;
  logic [wsjs_pkg::LIMIT_W-1:0] limit_r;

  logic              rd_glb_r;
  logic [JW-1:0]     lrd_r, grd_r;
  logic [1:0]        res_status_r, res_src_r;
  logic              res_read_r;

  logic              ov_r;
  logic [1:0]        ost_r, osrc_r;
  logic [JW-1:0]     ojob_r;
  logic [PW-1:0]     opend_r;

  logic [WW-1:0]     w;
  logic [2:0]        act;
  logic              vic_hit;
  logic [WW-1:0]     vic;
  logic [LCW-1:0]    lim_eff;
  logic              acc;

  function automatic logic [WW-1:0] wrap_w(input int unsigned x);
    int unsigned y;
    y = x;
    for (int i = 0; i < 4; i++) begin
      if (y >= WORKERS) y = y - WORKERS;
    end
    return WW'(y);
  endfunction

  function automatic logic [LW-1:0] wrap_l(input int unsigned x);
    return (x >= LOCAL_DEPTH) ? LW'(x - LOCAL_DEPTH) : LW'(x);
  endfunction

  function automatic logic [GW-1:0] wrap_g(input int unsigned x);
    return (x >= GLOBAL_DEPTH) ? GW'(x - GLOBAL_DEPTH) : GW'(x);
  endfunction

  function automatic logic [LAW-1:0] laddr(input logic [WW-1:0] wi, input logic [LW-1:0] idx);
    return LAW'(32'(wi) * LOCAL_DEPTH + 32'(idx));
  endfunction

  always_comb begin
    w = wrap_w(32'(in_worker));
    act = in_action;
    lim_eff = (32'(limit_r) < LOCAL_DEPTH) ? LCW'(limit_r) : LCW'(LOCAL_DEPTH);
    vic_hit = 1'b0;
    vic = w;
    for (int k = WORKERS - 1; k >= 1; k--) begin
      if (count_r[wrap_w(32'(w) + 32'(k))] != '0) begin
        vic_hit = 1'b1;
        vic = wrap_w(32'(w) + 32'(k));
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ghead_r  <= '0;
      gcount_r <= '0;
      pend_r   <= '0;
      stop_r   <= 1'b0;
      limit_r  <= wsjs_pkg::LIMIT_RESET;
      ov_r     <= 1'b0;
      for (int i = 0; i < WORKERS; i++) begin
        front_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (state_r == S_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            state_r      <= S_READ;
            res_status_r <= wsjs_pkg::ST_OK;
            res_src_r    <= wsjs_pkg::SRC_NONE;
            res_read_r   <= 1'b0;
            rd_glb_r     <= 1'b0;
            unique case (act)
              wsjs_pkg::ACT_EXT_SUBMIT: begin
                if (stop_r) res_status_r <= wsjs_pkg::ST_STOPPED;
                else if (32'(gcount_r) >= GLOBAL_DEPTH) res_status_r <= wsjs_pkg::ST_FULL;
                else begin
                  global_mem[wrap_g(32'(ghead_r) + 32'(gcount_r))] <= in_job_id;
                  gcount_r <= gcount_r + 1'b1;
                  if (pend_r != wsjs_pkg::PENDING_MAX) pend_r <= pend_r + 1'b1;
                end
              end
              wsjs_pkg::ACT_WRK_SUBMIT: begin
                if (stop_r) res_status_r <= wsjs_pkg::ST_STOPPED;
                else if (count_r[w] >= lim_eff) res_status_r <= wsjs_pkg::ST_FULL;
                else begin
                  local_mem[laddr(w, wrap_l(32'(front_r[w]) + 32'(count_r[w])))] <= in_job_id;
                  count_r[w] <= count_r[w] + 1'b1;
                  if (pend_r != wsjs_pkg::PENDING_MAX) pend_r <= pend_r + 1'b1;
                end
              end
              wsjs_pkg::ACT_FETCH: begin
                if (stop_r) res_status_r <= wsjs_pkg::ST_STOPPED;
                else if (count_r[w] != '0) begin
                  lrd_r <= local_mem[laddr(w,
                             wrap_l(32'(front_r[w]) + 32'(count_r[w]) - 32'd1))];
                  count_r[w] <= count_r[w] - 1'b1;
                  res_src_r  <= wsjs_pkg::SRC_OWN;
                  res_read_r <= 1'b1;
                end else if (gcount_r != '0) begin
                  grd_r      <= global_mem[ghead_r];
                  ghead_r    <= wrap_g(32'(ghead_r) + 32'd1);
                  gcount_r   <= gcount_r - 1'b1;
                  rd_glb_r   <= 1'b1;
                  res_src_r  <= wsjs_pkg::SRC_GLOBAL;
                  res_read_r <= 1'b1;
                end else if (vic_hit) begin
                  lrd_r <= local_mem[laddr(vic, front_r[vic])];
                  front_r[vic] <= wrap_l(32'(front_r[vic]) + 32'd1);
                  count_r[vic] <= count_r[vic] - 1'b1;
                  res_src_r  <= wsjs_pkg::SRC_STOLEN;
                  res_read_r <= 1'b1;
                end else res_status_r <= wsjs_pkg::ST_EMPTY;
              end
              wsjs_pkg::ACT_STOP: stop_r <= 1'b1;
              wsjs_pkg::ACT_DONE: if (pend_r != '0) pend_r <= pend_r - 1'b1;
              default: ;
            endcase
          end
        end
        S_READ: state_r <= S_OUT;
        S_OUT: begin
          if (!ov_r || !out_stall) begin
            ost_r   <= res_status_r;
            osrc_r  <= res_src_r;
            ojob_r  <= !res_read_r ? '0 : (rd_glb_r ? grd_r : lrd_r);
            opend_r <= pend_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_source     = osrc_r;
  assign out_job_id_res = ojob_r;
  assign out_pending    = opend_r;

  a_ack_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == S_READ) else $error("accept did not start read");
  a_src_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_source != wsjs_pkg::SRC_NONE |-> out_status == wsjs_pkg::ST_OK)
    else $error("source without ok");
  a_gcount: assert property (@(posedge clk) disable iff (!rst_n)
    32'(gcount_r) <= GLOBAL_DEPTH) else $error("global count overflow");
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the work-stealing job scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  localparam int NW = 4;
  localparam int LDEP = 64;
  localparam int GDEP = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int EXP_DEPTH = 16;
  localparam int NROWS = 14;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] job;
    logic [1:0]  src;
    logic [9:0]  pend;
  } result_t;

  typedef struct {
    logic [2:0]  act;
    logic [1:0]  wrk;
    logic [15:0] job;
    bit          fixed;
    result_t     res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [1:0] in_worker = '0;
  logic [15:0] in_job_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [15:0] out_job_id_res;
  logic [1:0] out_source;
  logic [9:0] out_pending;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  work_stealing_job_scheduler uut (.*);

  always #2 clk = ~clk;

  logic [15:0] dq_mem [NW][LDEP];
  int unsigned dq_front [NW];
  int unsigned dq_cnt [NW];
  logic [15:0] gq_mem [GDEP];
  int unsigned gq_head, gq_cnt, pend_cnt, lim;
  bit halted;
  result_t exp_mem [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int mismatches = 0;
  bit timed_out = 0;
  bit no_idle = 0;
  bit rx_hold = 0;
  int unsigned cycles = 0;

  function automatic result_t schedule(logic [2:0] act, logic [1:0] wrk, logic [15:0] job);
    result_t r;
    int unsigned w, v;
    r = '{wsjs_pkg::ST_OK, 16'd0, wsjs_pkg::SRC_NONE, 10'd0};
    w = wrk % NW;
    case (act)
      wsjs_pkg::ACT_EXT_SUBMIT: begin
        if (halted) r.status = wsjs_pkg::ST_STOPPED;
        else if (gq_cnt >= GDEP) r.status = wsjs_pkg::ST_FULL;
        else begin
          gq_mem[(gq_head + gq_cnt) % GDEP] = job;
          gq_cnt++;
          if (pend_cnt < 1023) pend_cnt++;
        end
      end
      wsjs_pkg::ACT_WRK_SUBMIT: begin
        if (halted) r.status = wsjs_pkg::ST_STOPPED;
        else if (dq_cnt[w] >= ((lim < LDEP) ? lim : LDEP)) r.status = wsjs_pkg::ST_FULL;
        else begin
          dq_mem[w][(dq_front[w] + dq_cnt[w]) % LDEP] = job;
          dq_cnt[w]++;
          if (pend_cnt < 1023) pend_cnt++;
        end
      end
      wsjs_pkg::ACT_FETCH: begin
        if (halted) r.status = wsjs_pkg::ST_STOPPED;
        else if (dq_cnt[w] > 0) begin
          r.job = dq_mem[w][(dq_front[w] + dq_cnt[w] - 1) % LDEP];
          dq_cnt[w]--;
          r.src = wsjs_pkg::SRC_OWN;
        end else if (gq_cnt > 0) begin
          r.job = gq_mem[gq_head];
          gq_head = (gq_head + 1) % GDEP;
          gq_cnt--;
          r.src = wsjs_pkg::SRC_GLOBAL;
        end else begin
          r.status = wsjs_pkg::ST_EMPTY;
          for (int off = 1; off < NW; off++) begin
            v = (w + off) % NW;
            if (dq_cnt[v] != 0 && r.src == wsjs_pkg::SRC_NONE) begin
              r.job = dq_mem[v][dq_front[v]];
              dq_front[v] = (dq_front[v] + 1) % LDEP;
              dq_cnt[v]--;
              r.src = wsjs_pkg::SRC_STOLEN;
              r.status = wsjs_pkg::ST_OK;
            end
          end
        end
      end
      wsjs_pkg::ACT_STOP: halted = 1;
      wsjs_pkg::ACT_DONE: if (pend_cnt > 0) pend_cnt--;
      default: ;
    endcase
    r.pend = pend_cnt[9:0];
    return r;
  endfunction

  task automatic send_word(logic [2:0] act, logic [1:0] wrk, logic [15:0] job,
                           bit fixed = 0, result_t fres = '0);
    result_t r;
    if (!no_idle) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_worker <= wrk;
    in_job_id <= job;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = schedule(act, wrk, job);
    if (fixed && r != fres) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %0d/%0d: typed %h, predicted %h", act, wrk, fres, r);
    end
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_limit(int unsigned val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= val[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word(int unsigned mostly_w);
    logic [2:0] act;
    int unsigned p;
    p = $urandom_range(99);
    if (p < 25) act = wsjs_pkg::ACT_WRK_SUBMIT;
    else if (p < 45) act = wsjs_pkg::ACT_EXT_SUBMIT;
    else if (p < 80) act = wsjs_pkg::ACT_FETCH;
    else if (p < 97) act = wsjs_pkg::ACT_DONE;
    else act = 3'($urandom_range(7, 5));
    send_word(act, (p & 1) ? 2'(mostly_w) : 2'($urandom_range(3)), 16'($urandom));
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_job_id_res, out_source, out_pending};
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected st=%0d job=%h src=%0d pend=%0d, %s",
                     want.status, want.job, want.src, want.pend,
                     $sformatf("got st=%0d job=%h src=%0d pend=%0d",
                               got.status, got.job, got.src, got.pend));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold) out_stall <= 1'b1;
    else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      timed_out = 1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t rows [NROWS];
    for (int i = 0; i < NW; i++) begin
      dq_front[i] = 0;
      dq_cnt[i] = 0;
    end
    gq_head = 0;
    gq_cnt = 0;
    pend_cnt = 0;
    lim = 64;
    halted = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows[0] = '{wsjs_pkg::ACT_FETCH, 2'd0, 16'h0, 1,
                '{wsjs_pkg::ST_EMPTY, 16'h0, wsjs_pkg::SRC_NONE, 10'd0}};
    rows[1] = '{wsjs_pkg::ACT_DONE, 2'd1, 16'h0, 1,
                '{wsjs_pkg::ST_OK, 16'h0, wsjs_pkg::SRC_NONE, 10'd0}};
    rows[2] = '{wsjs_pkg::ACT_EXT_SUBMIT, 2'd0, 16'hFFFF, 1,
                '{wsjs_pkg::ST_OK, 16'h0, wsjs_pkg::SRC_NONE, 10'd1}};
    rows[3] = '{wsjs_pkg::ACT_WRK_SUBMIT, 2'd3, 16'h0000, 1,
                '{wsjs_pkg::ST_OK, 16'h0, wsjs_pkg::SRC_NONE, 10'd2}};
    rows[4] = '{wsjs_pkg::ACT_WRK_SUBMIT, 2'd3, 16'hA5A5, 0, '0};
    rows[5] = '{wsjs_pkg::ACT_WRK_SUBMIT, 2'd2, 16'h5A5A, 0, '0};
    rows[6] = '{wsjs_pkg::ACT_FETCH, 2'd3, 16'h0, 0, '0};
    rows[7] = '{wsjs_pkg::ACT_FETCH, 2'd1, 16'h0, 0, '0};
    rows[8] = '{wsjs_pkg::ACT_FETCH, 2'd1, 16'h0, 0, '0};
    rows[9] = '{wsjs_pkg::ACT_FETCH, 2'd1, 16'h0, 0, '0};
    rows[10] = '{wsjs_pkg::ACT_FETCH, 2'd1, 16'h0, 0, '0};
    rows[11] = '{3'd5, 2'd0, 16'h1234, 0, '0};
    rows[12] = '{3'd7, 2'd3, 16'hFFFF, 0, '0};
    rows[13] = '{wsjs_pkg::ACT_DONE, 2'd0, 16'h0, 0, '0};
    foreach (rows[i]) send_word(rows[i].act, rows[i].wrk, rows[i].job, rows[i].fixed, rows[i].res);

    set_limit(0);
    send_word(wsjs_pkg::ACT_WRK_SUBMIT, 2'd1, 16'h0101, 1,
              '{wsjs_pkg::ST_FULL, 16'h0, wsjs_pkg::SRC_NONE, 10'd3});
    set_limit(127);
    for (int i = 0; i < LDEP + 1; i++) send_word(wsjs_pkg::ACT_WRK_SUBMIT, 2'd0, 16'($urandom));
    for (int i = 0; i < GDEP + 1; i++)
      send_word(wsjs_pkg::ACT_EXT_SUBMIT, 2'($urandom), 16'($urandom));

    // hold the receiver while the sender keeps offering
    fork
      begin
        rx_hold = 1;
        repeat (60) @(negedge clk);
        rx_hold = 0;
      end
      for (int i = 0; i < 20; i++) send_word(wsjs_pkg::ACT_FETCH, 2'($urandom), 16'h0);
    join
    drain();

    set_limit(3);
    no_idle = 1;
    for (int i = 0; i < 30; i++) random_word(0);
    no_idle = 0;
    set_limit(64);
    for (int i = 0; i < 30; i++) random_word($urandom_range(3));
    drain();

    send_word(wsjs_pkg::ACT_STOP, 2'd0, 16'h0);
    send_word(wsjs_pkg::ACT_STOP, 2'd2, 16'h0);
    send_word(wsjs_pkg::ACT_EXT_SUBMIT, 2'd1, 16'h7777);
    send_word(wsjs_pkg::ACT_WRK_SUBMIT, 2'd1, 16'h7777);
    send_word(wsjs_pkg::ACT_FETCH, 2'd2, 16'h0);
    send_word(wsjs_pkg::ACT_DONE, 2'd3, 16'h0);

    drain();
    if (mismatches == 0 && !timed_out) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

[work_stealing_job_scheduler.f]
src/wsjs_pkg.sv
src/work_stealing_job_scheduler.sv
tb/tb_top.sv
